@@ rtl/sorted_event_table_top_assert.svh @@
// Assertion macros for the sorted event table, clocked on i_clk and disabled in reset.
`ifndef SORTED_EVENT_TABLE_TOP_ASSERT_SVH
`define SORTED_EVENT_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SEVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted event table check failed");
`define SEVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted event table check failed");
`else
`define SEVT_ASSERT_IMP(label, ante, cons)
`define SEVT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/sevt_pkg.sv @@
// Shared types, constants and codes of the sorted event table.
`timescale 1ns / 1ps
package sevt_pkg;

    localparam int DEPTH       = 64;
    localparam int TAG_WIDTH   = 16;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int EXT_W       = COUNT_W + 1;
    localparam int DATE_W      = 27;
    localparam int TIME_W      = 14;
    localparam int TAG_PORT_W  = 16;
    localparam int HM_W        = 7;
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 2;

    // Quotient by 100 as a multiplication by a scaled reciprocal; exact for 14-bit times.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = TIME_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [TIME_W-1:0]  HUNDRED   = 14'd100;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VIEW   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic [DATE_W-1:0]    date;
        logic [TIME_W-1:0]    time_key;
        logic [TAG_WIDTH-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        t_entry              entry;
        logic                last;
    } t_result;

endpackage

@@ rtl/sorted_event_table_top.sv @@
// Top level of the sorted event table: request sequencer, entry store and result stage.
`timescale 1ns / 1ps
// The block keeps up to 64 entries of (date, time, tag) in ascending key order.
// A request is presented on i_req_type, i_date, i_time_req and i_tag and is taken
// as a transfer at a rising edge where start is high and busy is low. Busy stays
// high while the sequencer walks the entry store, so one request is in work at a time.
// Results leave on the o_ ports, each valid for exactly one cycle while o_strobe is
// high; o_last marks the final result of a request. The receiver cannot stall, so
// every result is taken in the cycle it is shown.
// All work goes through one store (one write, one registered read per cycle) and
// one shared key comparator, so the step count sets the timing. The steps are:
//   insert: each stored entry with a greater key moves up one place, from the back,
//           then the new entry is written into the gap;
//   delete: a search from the front for the entry, then each later entry moves down
//           one place; when no entry matches, the search runs through all entries;
//   view:   one entry result per cycle, in key order;
//   a full insert, a delete or view of an empty table, and an unused code are done at once.
// Results pass the registered hours/minutes split in the output stage before they leave.
// A synchronous active-low reset empties the table at once; the store itself is not
// cleared, since only entries below the fill count are ever used.
module sorted_event_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sevt_pkg::REQ_W-1:0]          i_req_type,
    input  logic [sevt_pkg::DATE_W-1:0]         i_date,
    input  logic [sevt_pkg::TIME_W-1:0]         i_time_req,
    input  logic [sevt_pkg::TAG_PORT_W-1:0]     i_tag,
    output logic                                o_strobe,
    output logic [sevt_pkg::STATUS_W-1:0]       o_status,
    output logic [sevt_pkg::DATE_W-1:0]         o_entry_date,
    output logic [sevt_pkg::TIME_W-1:0]         o_entry_time,
    output logic [sevt_pkg::HM_W-1:0]           o_entry_hours,
    output logic [sevt_pkg::HM_W-1:0]           o_entry_minutes,
    output logic [sevt_pkg::TAG_PORT_W-1:0]     o_entry_tag,
    output logic                                o_last
);

`include "sorted_event_table_top_assert.svh"

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;  // walk down, moving greater keys up by one
    localparam logic [2:0] S_DEL  = 3'd2;  // search from the front for a matching key
    localparam logic [2:0] S_SHF  = 3'd3;  // close the gap left by the deleted entry
    localparam logic [2:0] S_VIEW = 3'd4;  // emit one entry per cycle

    logic [2:0]                     r_state, n_state;
    logic [sevt_pkg::ADDR_W-1:0]    r_ptr, n_ptr;
    logic [sevt_pkg::COUNT_W-1:0]   r_count, n_count;
    sevt_pkg::t_entry               r_key, n_key;

    sevt_pkg::t_mem_req             w_mem_req;
    sevt_pkg::t_entry               w_rdata;
    sevt_pkg::t_cmp                 w_cmp;
    sevt_pkg::t_result              w_res;

    logic [sevt_pkg::EXT_W-1:0]     w_ptr_x;
    logic [sevt_pkg::EXT_W-1:0]     w_cnt_x;
    logic                           w_at_last;
    logic                           w_at_second_last;
    logic                           w_full;

    assign busy             = (r_state != S_IDLE);
    assign w_ptr_x          = sevt_pkg::EXT_W'(r_ptr);
    assign w_cnt_x          = sevt_pkg::EXT_W'(r_count);
    assign w_at_last        = (w_ptr_x + 1'b1 == w_cnt_x);
    assign w_at_second_last = (w_ptr_x + 2'd2 == w_cnt_x);
    assign w_full           = (r_count == sevt_pkg::COUNT_W'(sevt_pkg::DEPTH));

    sevt_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    sevt_cmp u_cmp (
        .i_stored (w_rdata),
        .i_key    (r_key),
        .o_cmp    (w_cmp)
    );

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_key   = r_key;

        w_mem_req.we    = 1'b0;
        w_mem_req.waddr = r_ptr;
        w_mem_req.wdata = r_key;
        w_mem_req.raddr = r_ptr;

        w_res.valid  = 1'b0;
        w_res.status = sevt_pkg::ST_ADDED;
        w_res.entry  = '0;
        w_res.last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key.date     = i_date;
                    n_key.time_key = i_time_req;
                    n_key.tag      = i_tag[sevt_pkg::TAG_WIDTH-1:0];
                    case (i_req_type)
                        sevt_pkg::REQ_INSERT: begin
                            if (w_full) begin
                                w_res.valid  = 1'b1;
                                w_res.status = sevt_pkg::ST_FULL;
                            end else begin
                                n_ptr           = sevt_pkg::ADDR_W'(r_count);
                                w_mem_req.raddr = sevt_pkg::ADDR_W'(r_count - 1'b1);
                                n_state         = S_INS;
                            end
                        end
                        sevt_pkg::REQ_DELETE: begin
                            if (r_count == '0) begin
                                w_res.valid  = 1'b1;
                                w_res.status = sevt_pkg::ST_NOT_FOUND;
                            end else begin
                                n_ptr           = '0;
                                w_mem_req.raddr = '0;
                                n_state         = S_DEL;
                            end
                        end
                        sevt_pkg::REQ_VIEW: begin
                            if (r_count == '0) begin
                                w_res.valid  = 1'b1;
                                w_res.status = sevt_pkg::ST_EMPTY;
                            end else begin
                                n_ptr           = '0;
                                w_mem_req.raddr = '0;
                                n_state         = S_VIEW;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS: begin
                w_mem_req.we    = 1'b1;
                w_mem_req.waddr = r_ptr;
                if ((r_ptr != '0) && w_cmp.gt) begin
                    w_mem_req.wdata = w_rdata;
                    w_mem_req.raddr = r_ptr - 2'd2;
                    n_ptr           = r_ptr - 1'b1;
                end else begin
                    w_mem_req.wdata = r_key;
                    n_count         = r_count + 1'b1;
                    w_res.valid     = 1'b1;
                    w_res.status    = sevt_pkg::ST_ADDED;
                    n_state         = S_IDLE;
                end
            end

            S_DEL: begin
                if (w_cmp.eq) begin
                    if (w_at_last) begin
                        n_count      = r_count - 1'b1;
                        w_res.valid  = 1'b1;
                        w_res.status = sevt_pkg::ST_DELETED;
                        n_state      = S_IDLE;
                    end else begin
                        w_mem_req.raddr = r_ptr + 1'b1;
                        n_state         = S_SHF;
                    end
                end else if (w_at_last) begin
                    w_res.valid  = 1'b1;
                    w_res.status = sevt_pkg::ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_ptr           = r_ptr + 1'b1;
                    w_mem_req.raddr = r_ptr + 1'b1;
                end
            end

            S_SHF: begin
                w_mem_req.we    = 1'b1;
                w_mem_req.waddr = r_ptr;
                w_mem_req.wdata = w_rdata;
                w_mem_req.raddr = r_ptr + 2'd2;
                n_ptr           = r_ptr + 1'b1;
                if (w_at_second_last) begin
                    n_count      = r_count - 1'b1;
                    w_res.valid  = 1'b1;
                    w_res.status = sevt_pkg::ST_DELETED;
                    n_state      = S_IDLE;
                end
            end

            S_VIEW: begin
                w_res.valid     = 1'b1;
                w_res.status    = sevt_pkg::ST_ENTRY;
                w_res.entry     = w_rdata;
                w_res.last      = w_at_last;
                n_ptr           = r_ptr + 1'b1;
                w_mem_req.raddr = r_ptr + 1'b1;
                if (w_at_last) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_key <= n_key;
    end

    sevt_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (w_res),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_entry_date    (o_entry_date),
        .o_entry_time    (o_entry_time),
        .o_entry_hours   (o_entry_hours),
        .o_entry_minutes (o_entry_minutes),
        .o_entry_tag     (o_entry_tag),
        .o_last          (o_last)
    );

    // The fill count never passes the table depth.
    `SEVT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= sevt_pkg::COUNT_W'(sevt_pkg::DEPTH))
    // An insert into a full table leaves the fill count alone.
    `SEVT_ASSERT_NEXT(a_full_keeps_count,
        start && !busy && (i_req_type == sevt_pkg::REQ_INSERT) && w_full,
        r_count == $past(r_count))
    // While inserting, the write slot never lies beyond the current fill count.
    `SEVT_ASSERT_IMP(a_ins_ptr_bound, r_state == S_INS, w_ptr_x <= w_cnt_x)
    // Every result the sequencer makes while busy in a search or shift ends the request.
    `SEVT_ASSERT_IMP(a_del_single_result,
        w_res.valid && ((r_state == S_DEL) || (r_state == S_SHF)),
        w_res.last && (n_state == S_IDLE))

endmodule

@@ rtl/sevt_mem.sv @@
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
module sevt_mem (
    input  logic               i_clk,
    input  sevt_pkg::t_mem_req i_req,
    output sevt_pkg::t_entry   o_rdata
);

    sevt_pkg::t_entry r_mem [sevt_pkg::DEPTH];
    sevt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sevt_cmp.sv @@
// Shared key comparator: orders a stored entry against the request key by date, then time.
`timescale 1ns / 1ps
module sevt_cmp (
    input  sevt_pkg::t_entry i_stored,
    input  sevt_pkg::t_entry i_key,
    output sevt_pkg::t_cmp   o_cmp
);

    logic w_date_eq;

    assign w_date_eq = (i_stored.date == i_key.date);
    assign o_cmp.eq  = w_date_eq && (i_stored.time_key == i_key.time_key);
    assign o_cmp.gt  = (i_stored.date > i_key.date)
                    || (w_date_eq && (i_stored.time_key > i_key.time_key));

endmodule

@@ rtl/sevt_out.sv @@
// Result output stage: splits the time into hours and minutes over two registered steps.
`timescale 1ns / 1ps
module sevt_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sevt_pkg::t_result                   i_res,
    output logic                                o_strobe,
    output logic [sevt_pkg::STATUS_W-1:0]       o_status,
    output logic [sevt_pkg::DATE_W-1:0]         o_entry_date,
    output logic [sevt_pkg::TIME_W-1:0]         o_entry_time,
    output logic [sevt_pkg::HM_W-1:0]           o_entry_hours,
    output logic [sevt_pkg::HM_W-1:0]           o_entry_minutes,
    output logic [sevt_pkg::TAG_PORT_W-1:0]     o_entry_tag,
    output logic                                o_last
);

    logic                             r_s1_valid;
    logic [sevt_pkg::STATUS_W-1:0]    r_s1_status;
    sevt_pkg::t_entry                 r_s1_entry;
    logic                             r_s1_last;
    logic [sevt_pkg::QUOT_W-1:0]      r_quot;
    logic [sevt_pkg::PROD_W-1:0]      w_prod;
    logic [sevt_pkg::TIME_W-1:0]      w_rem;

    assign w_prod = sevt_pkg::PROD_W'(i_res.entry.time_key)
                  * sevt_pkg::PROD_W'(sevt_pkg::RECIP_100);

    // The remainder stays below 100, so the low bits carry it exactly.
    assign w_rem = r_s1_entry.time_key
                 - sevt_pkg::TIME_W'(r_quot) * sevt_pkg::HUNDRED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= i_res.valid;
            o_strobe   <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status     <= i_res.status;
        r_s1_entry      <= i_res.entry;
        r_s1_last       <= i_res.last;
        r_quot          <= w_prod[sevt_pkg::PROD_W-1:sevt_pkg::RECIP_SHIFT];
        o_status        <= r_s1_status;
        o_entry_date    <= r_s1_entry.date;
        o_entry_time    <= r_s1_entry.time_key;
        o_entry_hours   <= sevt_pkg::HM_W'(r_quot);
        o_entry_minutes <= sevt_pkg::HM_W'(w_rem);
        o_entry_tag     <= sevt_pkg::TAG_PORT_W'(r_s1_entry.tag);
        o_last          <= r_s1_last;
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the sorted event table: scoreboard, request driver and monitor.
`timescale 1ns / 1ps
// Requests go in at the falling clock edge and are taken as a transfer at the
// rising edge where start is high and busy is low. Results are sampled at the
// rising edge while o_strobe is high. The receiver can never stall.
//
// The scoreboard keeps its own ordered copy of the table. Each accepted request
// is applied to that copy and turned into the results it must produce. Each
// strobed result is then compared, field by field, with the oldest one waiting.
module tb;
    import sevt_pkg::*;

    // The one request code that the package leaves unnamed. The block must ignore it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Times are decimal HHMM numbers, so hours and minutes split at this factor.
    localparam int HHMM_SCALE = 100;

    localparam logic [DATE_W-1:0] DATE_ALL_ONES = '1;
    localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;
    localparam int DATE_TOP  = 99991231;
    localparam int TIME_TOP  = 9999;

    // Sender idle percentage for each random phase. The first phase never idles.
    localparam int PHASE_IDLE [3] = '{0, 48, 15};
    localparam int PHASE_ITEMS    = 12;
    localparam int INSERT_WEIGHT  = 50;
    localparam int ALL_INSERTS    = 100;

    // Quiet cycles after the last expected result. This covers the result pipeline
    // and any stray result that an ignored request would wrongly produce.
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int RESET_CYCLES   = 4;

    // Fixed limit on the whole run. It is far above the slowest correct run.
    localparam int RUN_LIMIT_NS   = 2_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATE_W-1:0]     date;
        logic [TIME_W-1:0]     time_key;
        logic [HM_W-1:0]       hours;
        logic [HM_W-1:0]       minutes;
        logic [TAG_PORT_W-1:0] tag;
        logic                  is_last;
    } table_result_t;

    // Scoreboard: mirrors the table contents and checks results in order.
    class event_table_scoreboard;
        t_entry        rows[$];
        table_result_t outcomes[$];
        int            failures;
        int            results_seen;
        int            req_seen [4];
        int            refusals;
        int            deletes_hit;
        int            peak_fill;

        function table_result_t make_result(logic [STATUS_W-1:0] status, t_entry row,
                                            logic is_last);
            table_result_t r;
            r.status   = status;
            r.date     = row.date;
            r.time_key = row.time_key;
            r.hours    = HM_W'(row.time_key / HHMM_SCALE);
            r.minutes  = HM_W'(row.time_key % HHMM_SCALE);
            r.tag      = TAG_PORT_W'(row.tag);
            r.is_last  = is_last;
            return r;
        endfunction

        function string describe(table_result_t r);
            return $sformatf("status=%0d date=%0d time=%0d hh=%0d mm=%0d tag=%h last=%0b",
                             r.status, r.date, r.time_key, r.hours, r.minutes, r.tag,
                             r.is_last);
        endfunction

        // Applies one accepted request to the mirrored table and queues its results.
        function void note_request(logic [REQ_W-1:0] req, logic [DATE_W-1:0] date,
                                   logic [TIME_W-1:0] tm, logic [TAG_PORT_W-1:0] tag);
            t_entry row;
            int     pos;
            req_seen[req]++;
            row.date     = date;
            row.time_key = tm;
            row.tag      = tag[TAG_WIDTH-1:0];
            pos          = 0;
            case (req)
                REQ_INSERT: begin
                    if (rows.size() >= DEPTH) begin
                        refusals++;
                        outcomes.push_back(make_result(ST_FULL, '0, 1'b1));
                    end else begin
                        // The new row goes ahead of the first row with a greater key,
                        // so it lands behind any rows that carry an equal key.
                        while (pos < rows.size() &&
                               !(rows[pos].date > date ||
                                 (rows[pos].date == date && rows[pos].time_key > tm)))
                            pos++;
                        rows.insert(pos, row);
                        outcomes.push_back(make_result(ST_ADDED, '0, 1'b1));
                    end
                end
                REQ_DELETE: begin
                    while (pos < rows.size() &&
                           !(rows[pos].date == date && rows[pos].time_key == tm))
                        pos++;
                    if (pos < rows.size()) begin
                        rows.delete(pos);
                        deletes_hit++;
                        outcomes.push_back(make_result(ST_DELETED, '0, 1'b1));
                    end else begin
                        outcomes.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
                    end
                end
                REQ_VIEW: begin
                    if (rows.size() == 0)
                        outcomes.push_back(make_result(ST_EMPTY, '0, 1'b1));
                    else
                        foreach (rows[i])
                            outcomes.push_back(make_result(ST_ENTRY, rows[i],
                                                           i == rows.size() - 1));
                end
                default: ;
            endcase
            if (rows.size() > peak_fill)
                peak_fill = rows.size();
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            results_seen++;
            if (outcomes.size() == 0) begin
                if (failures < MAX_REPORTS)
                    $display("[%0t] result with nothing expected: %s", $time, describe(got));
                failures++;
                return;
            end
            want = outcomes.pop_front();
            if (got !== want) begin
                if (failures < MAX_REPORTS) begin
                    $display("[%0t] result mismatch", $time);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type;
    logic [DATE_W-1:0]     i_date;
    logic [TIME_W-1:0]     i_time_req;
    logic [TAG_PORT_W-1:0] i_tag;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [DATE_W-1:0]     o_entry_date;
    logic [TIME_W-1:0]     o_entry_time;
    logic [HM_W-1:0]       o_entry_hours;
    logic [HM_W-1:0]       o_entry_minutes;
    logic [TAG_PORT_W-1:0] o_entry_tag;
    logic                  o_last;

    event_table_scoreboard sb;
    int                    idle_pct;

    // Small pools of keys so that equal keys and delete hits come up often.
    logic [DATE_W-1:0] date_pool [4] = '{27'd20240101, 27'd20240102, 27'd19991231,
                                         27'd20300615};
    logic [TIME_W-1:0] time_pool [4] = '{14'd0, 14'd1230, 14'd1231, 14'd2359};

    sorted_event_table_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_date          (i_date),
        .i_time_req      (i_time_req),
        .i_tag           (i_tag),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_entry_date    (o_entry_date),
        .o_entry_time    (o_entry_time),
        .o_entry_hours   (o_entry_hours),
        .o_entry_minutes (o_entry_minutes),
        .o_entry_tag     (o_entry_tag),
        .o_last          (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Monitor. The result is checked before the new request is noted. A request
    // taken at this edge cannot have a result out at the same edge, so the order
    // of the two never changes what is compared.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                sb.check_result('{o_status, o_entry_date, o_entry_time, o_entry_hours,
                                  o_entry_minutes, o_entry_tag, o_last});
            end else if (o_strobe !== 1'b0) begin
                if (sb.failures < MAX_REPORTS)
                    $display("[%0t] result strobe is not a known level", $time);
                sb.failures++;
            end
            if (start && busy === 1'b0)
                sb.note_request(i_req_type, i_date, i_time_req, i_tag);
        end
    end

    function automatic logic [DATE_W-1:0] pick_date();
        case ($urandom_range(0, 9))
            0:       return DATE_W'($urandom);
            1:       return DATE_W'($urandom_range(0, DATE_TOP));
            default: return date_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return TIME_W'($urandom);
            1:       return TIME_W'($urandom_range(0, TIME_TOP));
            default: return time_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    // Presents one request just after a falling edge and holds it until the
    // transfer happens. It returns at the rising edge of the transfer.
    task automatic issue(logic [REQ_W-1:0] req, logic [DATE_W-1:0] d,
                         logic [TIME_W-1:0] t, logic [TAG_PORT_W-1:0] g);
        start      <= 1'b1;
        i_req_type <= req;
        i_date     <= d;
        i_time_req <= t;
        i_tag      <= g;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Lowers start for a random gap, at the rate of the current phase. Gaps are
    // mostly short, with a long one now and then.
    task automatic sender_gap();
        if ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3) + (($urandom_range(0, 19) == 0) ? 20 : 0))
                @(negedge i_clk);
        end
    endtask

    task automatic send(logic [REQ_W-1:0] req, logic [DATE_W-1:0] d,
                        logic [TIME_W-1:0] t, logic [TAG_PORT_W-1:0] g);
        @(negedge i_clk);
        issue(req, d, t, g);
        sender_gap();
    endtask

    // Random request. The request is built after the falling edge, when the
    // scoreboard already holds the table that follows the previous transfer.
    // Most deletes aim at a stored key, a few of those just miss it by one minute.
    task automatic send_random(int insert_weight);
        logic [REQ_W-1:0]      req;
        logic [DATE_W-1:0]     d;
        logic [TIME_W-1:0]     t;
        logic [TAG_PORT_W-1:0] g;
        int                    roll;
        t_entry                pick;
        @(negedge i_clk);
        roll = $urandom_range(0, 99);
        d    = pick_date();
        t    = pick_time();
        g    = TAG_PORT_W'($urandom);
        if (roll < insert_weight) begin
            req = REQ_INSERT;
        end else if (roll < insert_weight + 25) begin
            req = REQ_DELETE;
            if (sb.rows.size() > 0 && $urandom_range(0, 9) < 8) begin
                pick = sb.rows[$urandom_range(0, sb.rows.size() - 1)];
                d    = pick.date;
                t    = pick.time_key;
                if ($urandom_range(0, 7) == 0)
                    t = t + 1'b1;
            end
        end else if (roll < insert_weight + 40) begin
            req = REQ_VIEW;
        end else begin
            req = REQ_UNUSED;
        end
        issue(req, d, t, g);
        sender_gap();
    endtask

    // Stops sending until every expected result has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outcomes.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("run exceeded its time limit");
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        sb         = new();
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = REQ_INSERT;
        i_date     = '0;
        i_time_req = '0;
        i_tag      = '0;
        // Reset is held over a fixed number of rising edges, then let go at a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, equal keys kept in arrival order, the field
        // extremes, times above 9999, ignored requests, and deletes that match only
        // one half of the key.
        send(REQ_VIEW,   '0, '0, '0);
        send(REQ_DELETE, 27'd20240101, 14'd1230, '0);
        send(REQ_INSERT, 27'd20240101, 14'd1230, 16'h0001);
        send(REQ_INSERT, 27'd20240101, 14'd1230, 16'h0002);
        send(REQ_INSERT, DATE_ALL_ONES, TIME_ALL_ONES, 16'hFFFF);
        send(REQ_INSERT, '0, '0, '0);
        send(REQ_INSERT, DATE_W'(DATE_TOP), TIME_W'(TIME_TOP), 16'h5A5A);
        send(REQ_INSERT, 27'd20240101, 14'd1229, 16'hA5A5);
        send(REQ_INSERT, 27'd20240101, 14'd1230, 16'h0003);
        send(REQ_INSERT, 27'd20240101, 14'd100, 16'h1234);
        send(REQ_INSERT, 27'd20240102, 14'd59, 16'h4321);
        send(REQ_VIEW,   '0, '0, '0);
        send(REQ_UNUSED, DATE_ALL_ONES, TIME_ALL_ONES, 16'hFFFF);
        send(REQ_DELETE, 27'd20240101, 14'd1230, '0);
        send(REQ_DELETE, 27'd20240101, 14'd1231, '0);
        send(REQ_DELETE, 27'd20240103, 14'd1230, '0);
        send(REQ_DELETE, DATE_ALL_ONES, TIME_ALL_ONES, '0);
        send(REQ_DELETE, '0, '0, '0);
        send(REQ_VIEW,   '0, '0, '0);
        send(REQ_UNUSED, '0, '0, '0);
        send(REQ_INSERT, DATE_ALL_ONES, 14'd10000, 16'h8000);
        send(REQ_VIEW,   '0, '0, '0);
        drain();

        // Random phases. Each one ends by waiting for every result. In the middle
        // phase the table is filled to the brim, refuses a few more inserts and is
        // read out whole before the deletes thin it again.
        foreach (PHASE_IDLE[p]) begin
            idle_pct = PHASE_IDLE[p];
            repeat (PHASE_ITEMS / 2) send_random(INSERT_WEIGHT);
            if (p == 1) begin
                while (sb.rows.size() < DEPTH)
                    send_random(ALL_INSERTS);
                repeat (3) send_random(ALL_INSERTS);
                send(REQ_VIEW, '0, '0, '0);
            end
            repeat (PHASE_ITEMS - PHASE_ITEMS / 2) send_random(INSERT_WEIGHT);
            drain();
        end

        if (sb.outcomes.size() != 0) begin
            $display("%0d expected results never arrived", sb.outcomes.size());
            sb.failures += sb.outcomes.size();
        end
        $display("Requests: %0d inserts (%0d refused as full), %0d deletes (%0d hits),",
                 sb.req_seen[REQ_INSERT], sb.refusals, sb.req_seen[REQ_DELETE],
                 sb.deletes_hit);
        $display("  %0d views, %0d ignored; %0d results compared; table reached %0d of %0d rows.",
                 sb.req_seen[REQ_VIEW], sb.req_seen[REQ_UNUSED], sb.results_seen,
                 sb.peak_fill, DEPTH);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
